/* rtl/wvs_pkg.sv */
// ----------------------------------------------------------------------------
// wvs_pkg: shared types and constants of the weighted voxel sampler
// Field widths, register indexes, request and status codes.
// ----------------------------------------------------------------------------
package wvs_pkg;

	localparam int SIZE_W     = 13;            // size register width
	localparam int SUM_W      = 28;            // cumulative sum width
	localparam int FRAC_W     = 32;            // random fraction width
	localparam int IDX_W      = 12;            // index fields on the result
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int PLANE_W    = 2 * SIZE_W;    // size_x * size_y
	localparam int GRID_W     = 3 * SIZE_W;    // size_x * size_y * size_z
	localparam int TARGET_W   = FRAC_W + SUM_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
	localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// request kinds
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_LOADED = 2'd1,
		ST_ZERO_TOTAL = 2'd2,
		ST_OVERFLOW   = 2'd3
	} status_t;

endpackage

/* rtl/wvs_if.sv */
// ----------------------------------------------------------------------------
// wvs_if: request and response channels of the weighted voxel sampler
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface wvs_req_if #(
	parameter int WEIGHT_BITS = 16
);
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [WEIGHT_BITS-1:0]       weight;
	logic [wvs_pkg::FRAC_W-1:0]          rand_fraction;

	modport source (output valid, req_type, weight, rand_fraction, input ready);
	modport sink   (input valid, req_type, weight, rand_fraction, output ready);
endinterface

interface wvs_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [wvs_pkg::STATUS_W-1:0]        status;
	logic [wvs_pkg::IDX_W-1:0]           voxel_index;
	logic [wvs_pkg::IDX_W-1:0]           x_index;
	logic [wvs_pkg::IDX_W-1:0]           y_index;
	logic [wvs_pkg::IDX_W-1:0]           z_index;

	modport source (output valid, status, voxel_index, x_index, y_index, z_index,
		input ready);
	modport sink   (input valid, status, voxel_index, x_index, y_index, z_index,
		output ready);
endinterface

/* rtl/wvs_divider.sv */
// ----------------------------------------------------------------------------
// wvs_divider: restoring bit-serial divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
module wvs_divider #(
	parameter int NUM_W = 12,
	parameter int DEN_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			quot_q <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W);
				quot_q <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				quot_q <= (quot_q << 1) | NUM_W'(fits);
				rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* rtl/weighted_voxel_sampler.sv */
// ----------------------------------------------------------------------------
// weighted_voxel_sampler: discrete inverse-CDF sampling over a voxel grid
// Loads a cumulative weight table, then draws voxels by binary search.
// ----------------------------------------------------------------------------
// A load transaction (req_type 0) clamps a negative weight to zero, adds it to
// the saturating 28-bit running total and stores that sum at the next table
// position; it answers with the position written, or status 3 once the grid
// (or the table) is full. A sample transaction (req_type 1) takes
// r = rand_fraction / 2^32 and returns the first voxel whose cumulative sum is
// at least r times the total (the last voxel if none), as a flat index and
// x/y/z indices with x fastest. Samples before the whole grid is loaded, or
// with a zero or oversized grid, give status 1; a zero total gives status 2.
// A sample passes through a multiply state, a binary search in which each step
// is a registered table read followed by a compare, the exit from the search,
// two passes of a bit-serial divider (one quotient bit per cycle) for the
// index split, and the load of the response register once it is free. The
// request channel takes one transaction at a time. Writing a size register
// restarts loading and holds ready low until the grid size product (plane,
// then grid register) has settled. The table has no reset; only entries
// written since the last restart are read.
// ----------------------------------------------------------------------------
module weighted_voxel_sampler #(
	parameter int TABLE_DEPTH = 4096,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wvs_pkg::SIZE_W-1:0]     cfg_data,
	wvs_req_if.sink                        req,
	wvs_rsp_if.source                      rsp
);

	localparam int AW    = $clog2(TABLE_DEPTH);   // table address width
	localparam int CW    = AW + 1;                // count, holds TABLE_DEPTH
	localparam int SW    = wvs_pkg::SUM_W;
	localparam int SZW   = wvs_pkg::SIZE_W;
	localparam int PW    = wvs_pkg::PLANE_W;
	localparam int GW    = wvs_pkg::GRID_W;
	localparam int FW    = wvs_pkg::FRAC_W;
	localparam int TW    = wvs_pkg::TARGET_W;
	localparam int IW    = wvs_pkg::IDX_W;
	localparam int ADD_W = ((WEIGHT_BITS > SW) ? WEIGHT_BITS : SW) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DIV_Z,
		S_DIV_Y,
		S_OUT
	} state_t;

	// ---- configuration and derived grid size ----
	logic [SZW-1:0] size_x_q, size_y_q, size_z_q;
	logic [PW-1:0]  plane_q;        // size_x * size_y
	logic [GW-1:0]  grid_q;         // plane * size_z
	logic [1:0]     cfg_busy_q;     // cycles until grid_q is valid again
	logic           cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index == wvs_pkg::REG_SIZE_X ||
		cfg_index == wvs_pkg::REG_SIZE_Y || cfg_index == wvs_pkg::REG_SIZE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= wvs_pkg::SIZE_RESET;
			size_y_q   <= wvs_pkg::SIZE_RESET;
			size_z_q   <= wvs_pkg::SIZE_RESET;
			plane_q    <= PW'(wvs_pkg::SIZE_RESET) * PW'(wvs_pkg::SIZE_RESET);
			grid_q     <= GW'(wvs_pkg::SIZE_RESET) * GW'(wvs_pkg::SIZE_RESET) *
				GW'(wvs_pkg::SIZE_RESET);
			cfg_busy_q <= 2'd0;
		end else begin
			// two-stage product, recomputed every cycle
			plane_q <= PW'(size_x_q) * PW'(size_y_q);
			grid_q  <= GW'(plane_q) * GW'(size_z_q);
			if (cfg_busy_q != 2'd0)
				cfg_busy_q <= cfg_busy_q - 2'd1;
			if (cfg_hit) begin
				cfg_busy_q <= 2'd2;
				case (cfg_index)
					wvs_pkg::REG_SIZE_X: size_x_q <= cfg_data;
					wvs_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
					wvs_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// grid status flags
	logic          grid_zero, grid_big;
	logic [CW-1:0] grid_cnt;
	assign grid_zero = (grid_q == '0);
	assign grid_big  = (grid_q > GW'(TABLE_DEPTH));
	assign grid_cnt  = grid_q[CW-1:0];        // exact when !grid_big

	// ---- main control ----
	state_t                  state_q;
	logic [CW-1:0]           loaded_q;
	logic [SW-1:0]           total_q;
	logic [FW-1:0]           frac_q;
	logic [TW-1:0]           target_q;
	logic [CW-1:0]           lo_q, hi_q, mid_q;
	logic [AW-1:0]           idx_q, z_q;
	logic                    div_start_q;
	logic [AW-1:0]           div_num_q;
	logic [PW-1:0]           div_den_q;
	logic                    out_valid_q;
	wvs_pkg::status_t        out_status_q;
	logic [IW-1:0]           out_voxel_q, out_x_q, out_y_q, out_z_q;

	logic                    accept, out_free;
	logic                    load_full, sample_ok;
	logic [ADD_W-1:0]        add_sum;
	logic [SW-1:0]           sum_sat;
	logic [CW-1:0]           mid;
	logic                    rd_en;
	logic [SW-1:0]           rd_data_q;
	logic                    div_done;
	logic [AW-1:0]           div_quot;
	logic [PW-1:0]           div_rem;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && (cfg_busy_q == 2'd0) && out_free;
	assign accept    = req.valid && req.ready;

	// a load is dropped once the grid or the table is full
	assign load_full = (loaded_q == CW'(TABLE_DEPTH)) ||
		(!grid_big && (loaded_q >= grid_cnt));
	assign sample_ok = !grid_zero && !grid_big && (loaded_q == grid_cnt);

	// clamp negatives to zero, saturate the running total
	assign add_sum = ADD_W'(total_q) +
		(req.weight[WEIGHT_BITS-1] ? ADD_W'(0) : ADD_W'($unsigned(req.weight)));
	assign sum_sat = (add_sum > ADD_W'(wvs_pkg::SUM_MAX)) ? wvs_pkg::SUM_MAX
		: add_sum[SW-1:0];

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_en = (state_q == S_SRCH_RD) && (lo_q < hi_q);

	// ---- cumulative table: one write port, one registered read port ----
	logic [SW-1:0] cum_mem [TABLE_DEPTH];
	logic          mem_we;
	assign mem_we = accept && (req.req_type == wvs_pkg::REQ_LOAD) && !load_full;

	always_ff @(posedge clk) begin
		if (mem_we)
			cum_mem[loaded_q[AW-1:0]] <= sum_sat;
		if (rd_en)
			rd_data_q <= cum_mem[mid[AW-1:0]];
	end

	// ---- index split: flat / plane, then remainder / size_x ----
	wvs_divider #(
		.NUM_W (AW),
		.DEN_W (PW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			loaded_q     <= '0;
			total_q      <= '0;
			frac_q       <= '0;
			target_q     <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			idx_q        <= '0;
			z_q          <= '0;
			div_start_q  <= 1'b0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= wvs_pkg::ST_OK;
			out_voxel_q  <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_z_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (rsp.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_voxel_q <= '0;
						out_x_q     <= '0;
						out_y_q     <= '0;
						out_z_q     <= '0;
						if (req.req_type == wvs_pkg::REQ_LOAD) begin
							out_valid_q <= 1'b1;
							if (load_full) begin
								out_status_q <= wvs_pkg::ST_OVERFLOW;
							end else begin
								out_status_q <= wvs_pkg::ST_OK;
								out_voxel_q  <= IW'(loaded_q);
								total_q      <= sum_sat;
								loaded_q     <= loaded_q + 1'b1;
							end
						end else if (!sample_ok) begin
							out_valid_q  <= 1'b1;
							out_status_q <= wvs_pkg::ST_NOT_LOADED;
						end else if (total_q == '0) begin
							out_valid_q  <= 1'b1;
							out_status_q <= wvs_pkg::ST_ZERO_TOTAL;
						end else begin
							frac_q  <= req.rand_fraction;
							lo_q    <= '0;
							hi_q    <= loaded_q;
							state_q <= S_MULT;
						end
					end
				end
				S_MULT: begin
					target_q <= TW'(frac_q) * TW'(total_q);
					state_q  <= S_SRCH_RD;
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else begin
						// search done; if no entry qualified, fall back to the last voxel
						idx_q       <= (lo_q >= loaded_q) ? AW'(loaded_q - 1'b1)
							: AW'(lo_q);
						div_num_q   <= (lo_q >= loaded_q) ? AW'(loaded_q - 1'b1)
							: AW'(lo_q);
						div_den_q   <= plane_q;
						div_start_q <= 1'b1;
						state_q     <= S_DIV_Z;
					end
				end
				S_SRCH_CMP: begin
					if ({rd_data_q, {FW{1'b0}}} >= target_q)
						hi_q <= mid_q;
					else
						lo_q <= mid_q + 1'b1;
					state_q <= S_SRCH_RD;
				end
				S_DIV_Z: begin
					if (div_done) begin
						z_q         <= div_quot;
						div_num_q   <= AW'(div_rem);
						div_den_q   <= PW'(size_x_q);
						div_start_q <= 1'b1;
						state_q     <= S_DIV_Y;
					end
				end
				S_DIV_Y: begin
					if (div_done) begin
						out_y_q <= IW'(div_quot);
						out_x_q <= IW'(div_rem);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= wvs_pkg::ST_OK;
						out_voxel_q  <= IW'(idx_q);
						out_z_q      <= IW'(z_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// a size write restarts loading; the user must write sizes only while idle, the block itself does not enforce it
			if (cfg_hit) begin
				loaded_q <= '0;
				total_q  <= '0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.voxel_index = out_voxel_q;
	assign rsp.x_index     = out_x_q;
	assign rsp.y_index     = out_y_q;
	assign rsp.z_index     = out_z_q;

endmodule

/* tb/weighted_voxel_sampler_tb.sv */
// ----------------------------------------------------------------------------
// weighted_voxel_sampler_tb: self-checking bench for the weighted voxel sampler
// Loads voxel weight tables over many grid shapes and checks every response
// against typed results or a cycle-free model of the inverse-CDF table search.
// ----------------------------------------------------------------------------
module weighted_voxel_sampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wvs_pkg::*;

	localparam int TABLE_DEPTH   = 4096;
	localparam int WEIGHT_BITS   = 16;
	localparam int RANDOM_ITEMS  = 410;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int LAST_SIZE_XY  = 16;
	localparam int LAST_SIZE_Z   = 2;
	localparam int LAST_LOADS    = LAST_SIZE_XY * LAST_SIZE_XY * LAST_SIZE_Z;

	// the fourth register index decodes to nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   voxel;
		logic [IDX_W-1:0]   x;
		logic [IDX_W-1:0]   y;
		logic [IDX_W-1:0]   z;
	} voxel_result_t;

	localparam voxel_result_t RES_NONE       = '0;
	localparam voxel_result_t RES_OK_VOXEL0  = '{ST_OK, 12'd0, 12'd0, 12'd0, 12'd0};
	localparam voxel_result_t RES_OK_VOXEL1  = '{ST_OK, 12'd1, 12'd0, 12'd0, 12'd0};
	localparam voxel_result_t RES_NOT_LOADED = '{ST_NOT_LOADED, 12'd0, 12'd0, 12'd0, 12'd0};
	localparam voxel_result_t RES_ZERO_TOTAL = '{ST_ZERO_TOTAL, 12'd0, 12'd0, 12'd0, 12'd0};
	localparam voxel_result_t RES_OVERFLOW   = '{ST_OVERFLOW, 12'd0, 12'd0, 12'd0, 12'd0};

	// directed rows are either a request transaction or a register write
	typedef enum logic {STEP_REQUEST, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t              kind;
		logic                    req_type;
		logic [WEIGHT_BITS-1:0]  weight;
		logic [FRAC_W-1:0]       frac;
		logic [CFG_IDX_W-1:0]    reg_index;
		logic [SIZE_W-1:0]       reg_value;
		logic                    known;     // result typed in below, else predicted
		voxel_result_t           result;
	} directed_step_t;

	localparam int DIRECTED_ROWS = 40;

	// Walk through the corner cases first: reset sizes, empty and oversized
	// grids, clamped negative weights, a zero total, loads past the grid, an
	// ignored register index, a zero fraction landing on a zero-weight voxel,
	// and then a small 2x2x2 grid with mixed weights for the 3-D index split.
	localparam directed_step_t DIRECTED [DIRECTED_ROWS] = '{
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_NOT_LOADED},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0064, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OVERFLOW},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h8000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_NOT_LOADED},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd8191, 1'b0,
			RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Y, 13'd8191, 1'b0,
			RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Z, 13'd8191, 1'b0,
			RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0007, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL0},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'hFFFF_FFFF, REG_SIZE_X, 13'd0, 1'b1,
			RES_NOT_LOADED},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd4096, 1'b0,
			RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Y, 13'd1, 1'b0, RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Z, 13'd1, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h7FFF, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL0},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_NOT_LOADED},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd1, 1'b0, RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Z, 13'd2, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h8000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL0},
		'{STEP_REQUEST, REQ_LOAD,   16'hFFFF, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL1},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h8000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_ZERO_TOTAL},
		'{STEP_REQUEST, REQ_LOAD,   16'h0005, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OVERFLOW},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_UNUSED, 13'd8191, 1'b0,
			RES_NONE},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h1234_5678, REG_SIZE_X, 13'd0, 1'b1,
			RES_ZERO_TOTAL},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Z, 13'd2, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL0},
		'{STEP_REQUEST, REQ_LOAD,   16'h7FFF, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL1},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b1,
			RES_OK_VOXEL0},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'hFFFF_FFFF, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd2, 1'b0, RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Y, 13'd2, 1'b0, RES_NONE},
		'{STEP_WRITE,   REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_Z, 13'd2, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0001, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h7FFF, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h012C, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'hFFFB, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0002, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0000, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_LOAD,   16'h0009, 32'h0000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h8000_0000, REG_SIZE_X, 13'd0, 1'b0, RES_NONE},
		'{STEP_REQUEST, REQ_SAMPLE, 16'h0000, 32'h0000_0001, REG_SIZE_X, 13'd0, 1'b0, RES_NONE}
	};

	// ------------------------------------------------------------------------
	// Clock, reset, configuration port and channels
	// ------------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SIZE_W-1:0]     cfg_data;

	wvs_req_if #(.WEIGHT_BITS(WEIGHT_BITS)) req_ch ();
	wvs_rsp_if                              rsp_ch ();

	weighted_voxel_sampler #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: the bench's own copy of the sizes and of the table
	// ------------------------------------------------------------------------
	int unsigned         size_x = SIZE_RESET;
	int unsigned         size_y = SIZE_RESET;
	int unsigned         size_z = SIZE_RESET;
	int unsigned         filled_count = 0;
	logic [SUM_W-1:0]    total_sum = '0;
	logic [SUM_W-1:0]    cum_sums [TABLE_DEPTH];

	voxel_result_t       expected_voxels [$];
	int unsigned         mismatch_count = 0;
	int unsigned         items_sent = 0;
	int unsigned         cycle_count = 0;
	int unsigned         tx_idle_pct = 36;   // percent of cycles the sender holds off
	int unsigned         rx_idle_pct = 87;   // percent of cycles the receiver stalls

	// Advance the predictor by one accepted request and return its response.
	function automatic voxel_result_t step_voxel_model(logic kind,
			logic signed [WEIGHT_BITS-1:0] w, logic [FRAC_W-1:0] frac);
		voxel_result_t          res;
		longint unsigned        grid, plane, idx, rem, iz, iy;
		logic [SUM_W:0]         sum;
		logic [TARGET_W-1:0]    target;
		int unsigned            lo, hi, mid;
		res  = RES_NONE;
		grid = longint'(size_x) * size_y * size_z;
		if (kind == REQ_LOAD) begin
			if (filled_count >= grid || filled_count >= TABLE_DEPTH) begin
				res.status = ST_OVERFLOW;
			end else begin
				// negative weights count as zero; the running sum saturates
				sum = {1'b0, total_sum};
				if (!w[WEIGHT_BITS-1])
					sum += w[WEIGHT_BITS-2:0];
				if (sum > {1'b0, SUM_MAX})
					sum = {1'b0, SUM_MAX};
				total_sum = sum[SUM_W-1:0];
				cum_sums[filled_count] = total_sum;
				res.voxel = IDX_W'(filled_count);
				filled_count++;
			end
		end else if (grid == 0 || grid > TABLE_DEPTH || filled_count != grid) begin
			res.status = ST_NOT_LOADED;
		end else if (total_sum == 0) begin
			res.status = ST_ZERO_TOTAL;
		end else begin
			// first entry with cum * 2^32 >= r * total, else the last one
			target = TARGET_W'(frac) * TARGET_W'(total_sum);
			lo = 0;
			hi = filled_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if ({cum_sums[mid], FRAC_W'(0)} >= target)
					hi = mid;
				else
					lo = mid + 1;
			end
			idx   = (lo >= filled_count) ? filled_count - 1 : lo;
			plane = longint'(size_x) * size_y;
			iz    = idx / plane;
			rem   = idx - iz * plane;
			iy    = rem / size_x;
			res.status = ST_OK;
			res.voxel  = IDX_W'(idx);
			res.x      = IDX_W'(rem - iy * size_x);
			res.y      = IDX_W'(iy);
			res.z      = IDX_W'(iz);
		end
		return res;
	endfunction

	// Weights: plenty of clamped negatives and zeros, small and full-range values.
	function automatic logic signed [WEIGHT_BITS-1:0] pick_weight();
		case ($urandom_range(9))
			0, 1:    return {1'b1, 15'($urandom)};
			2:       return '0;
			3, 4, 5: return WEIGHT_BITS'($urandom_range(15, 1));
			default: return WEIGHT_BITS'($urandom);
		endcase
	endfunction

	// Fractions: the ends of the range, points right on a cumulative step
	// (and one either side of it), and plain uniform values.
	function automatic logic [FRAC_W-1:0] pick_fraction();
		logic [TARGET_W-1:0]  split_point;
		int unsigned          pick;
		if (filled_count == 0 || total_sum == 0)
			return $urandom;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: begin
				pick = $urandom_range(filled_count - 1);
				split_point = {cum_sums[pick], FRAC_W'(0)} / total_sum;
				case ($urandom_range(2))
					0:       if (split_point != 0) split_point--;
					2:       split_point++;
					default: ;
				endcase
				return (split_point > TARGET_W'(32'hFFFF_FFFF)) ? '1 : split_point[FRAC_W-1:0];
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Request side. Inputs move on the falling edge; a transaction is seen
	// complete at the rising edge where valid and ready are both high, and
	// only then does the predictor step.
	// ------------------------------------------------------------------------
	task automatic put_request(logic kind, logic signed [WEIGHT_BITS-1:0] w,
			logic [FRAC_W-1:0] frac, bit use_known = 1'b0,
			voxel_result_t known = RES_NONE);
		voxel_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.weight        <= w;
		req_ch.rand_fraction <= frac;
		do @(posedge clk); while (!req_ch.ready);
		predicted = step_voxel_model(kind, w, frac);
		expected_voxels = {expected_voxels, (use_known ? known : predicted)};
		items_sent++;
	endtask

	// Hold the sender off until every outstanding response has come back.
	task automatic drain_responses();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_voxels.size() != 0)
			@(posedge clk);
	endtask

	// Size writes only land while the block is idle; each one (bar the unused
	// index) restarts loading in the predictor as well.
	task automatic write_size(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] value);
		drain_responses();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (index)
			REG_SIZE_X: size_x = value;
			REG_SIZE_Y: size_y = value;
			REG_SIZE_Z: size_z = value;
			default:    return;
		endcase
		filled_count = 0;
		total_sum    = '0;
	endtask

	// One random phase: a fresh grid, mostly loaded in full and then sampled,
	// with stray samples during the load, stray loads afterwards, the odd
	// load broken off early, and now and then a grid that can never be sampled.
	task automatic run_random_phase();
		int unsigned      nx, ny, nz, big, loads, samples, i;
		longint unsigned  grid;
		if ($urandom_range(6) == 0) begin
			nx = $urandom_range(3, 1);
			ny = $urandom_range(3, 1);
			nz = $urandom_range(3, 1);
			case ($urandom_range(2))
				0:       big = 0;
				1:       big = 4096;
				default: big = 8191;
			endcase
			case ($urandom_range(2))
				0:       nx = big;
				1:       ny = big;
				default: nz = big;
			endcase
		end else begin
			nx = $urandom_range(6, 1);
			ny = $urandom_range(4, 1);
			nz = $urandom_range(4, 1);
		end
		write_size(REG_SIZE_X, SIZE_W'(nx));
		write_size(REG_SIZE_Y, SIZE_W'(ny));
		write_size(REG_SIZE_Z, SIZE_W'(nz));
		grid = longint'(nx) * ny * nz;
		if (grid == 0 || grid > 96)
			loads = $urandom_range(6);
		else if ($urandom_range(9) == 0)
			loads = $urandom_range(int'(grid) - 1);
		else
			loads = grid;
		for (i = 0; i < loads; i++) begin
			if ($urandom_range(11) == 0)
				put_request(REQ_SAMPLE, pick_weight(), pick_fraction());
			put_request(REQ_LOAD, pick_weight(), $urandom);
		end
		samples = $urandom_range(30, 4);
		for (i = 0; i < samples; i++) begin
			if ($urandom_range(39) == 0)
				drain_responses();
			if ($urandom_range(11) == 0)
				put_request(REQ_LOAD, pick_weight(), $urandom);
			else
				put_request(REQ_SAMPLE, pick_weight(), pick_fraction());
		end
	endtask

	// ------------------------------------------------------------------------
	// Response side: random back-pressure, and a field-by-field check of each
	// response transaction against the oldest outstanding expectation.
	// ------------------------------------------------------------------------
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin : check_response
		voxel_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_voxels.size() == 0) begin
				report_mismatch("response with nothing outstanding, voxel_index",
					rsp_ch.voxel_index, 0);
			end else begin
				want = expected_voxels.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", rsp_ch.status, want.status);
				if (rsp_ch.voxel_index !== want.voxel)
					report_mismatch("voxel_index", rsp_ch.voxel_index, want.voxel);
				if (rsp_ch.x_index !== want.x)
					report_mismatch("x_index", rsp_ch.x_index, want.x);
				if (rsp_ch.y_index !== want.y)
					report_mismatch("y_index", rsp_ch.y_index, want.y);
				if (rsp_ch.z_index !== want.z)
					report_mismatch("z_index", rsp_ch.z_index, want.z);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned row_no, k;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_SIZE_X;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_LOAD;
		req_ch.weight        = '0;
		req_ch.rand_fraction = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, sender and receiver in the first idling pattern
		for (row_no = 0; row_no < DIRECTED_ROWS; row_no++) begin
			if (DIRECTED[row_no].kind == STEP_WRITE)
				write_size(DIRECTED[row_no].reg_index, DIRECTED[row_no].reg_value);
			else
				put_request(DIRECTED[row_no].req_type, DIRECTED[row_no].weight,
					DIRECTED[row_no].frac, DIRECTED[row_no].known, DIRECTED[row_no].result);
		end

		// random phases: receiver-idle third, sender-idle third, then flat out
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 36;
				rx_idle_pct = 87;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 87;
				rx_idle_pct = 36;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			run_random_phase();
		end

		// a 16x16x2 grid loaded to the end: a deep search, then a load past
		// the end of the grid
		write_size(REG_SIZE_X, SIZE_W'(LAST_SIZE_XY));
		write_size(REG_SIZE_Y, SIZE_W'(LAST_SIZE_XY));
		write_size(REG_SIZE_Z, SIZE_W'(LAST_SIZE_Z));
		for (k = 0; k < LAST_LOADS; k++)
			put_request(REQ_LOAD, pick_weight(), $urandom);
		for (k = 0; k < 60; k++)
			put_request(REQ_SAMPLE, pick_weight(), pick_fraction());
		put_request(REQ_LOAD, pick_weight(), $urandom);
		for (k = 0; k < 4; k++)
			put_request(REQ_SAMPLE, pick_weight(), pick_fraction());

		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
